@@ src/bwed_pkg.sv @@
// ----------------------------------------------------------------------------
// bwed_pkg: shared types and constants of the bowl weight event detector
// Word layouts, configuration register indexes, event codes and the
// internal groups of signals passed between the core, register file and queue.
// ----------------------------------------------------------------------------
package bwed_pkg;

  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned AMOUNT_W = 24;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Arithmetic width for differences of two weights and their negation
  localparam int unsigned CALC_W = WEIGHT_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DRINK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd3;

  localparam logic [CFG_W-1:0] DRINK_RESET    = 16'd64;
  localparam logic [CFG_W-1:0] REFILL_RESET   = 16'd128;
  localparam logic [CFG_W-1:0] PRESENCE_RESET = 16'd80;
  localparam logic [CFG_W-1:0] SETTLE_RESET   = 16'd16;

  localparam logic [CODE_W-1:0] EV_PLACED   = 3'd0;
  localparam logic [CODE_W-1:0] EV_BASELINE = 3'd1;
  localparam logic [CODE_W-1:0] EV_DRINK    = 3'd2;
  localparam logic [CODE_W-1:0] EV_REFILL   = 3'd3;
  localparam logic [CODE_W-1:0] EV_REMOVED  = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic                       is_stable;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]   event_code;
    logic [AMOUNT_W-1:0] amount;
    logic                is_last;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] drink_threshold;
    logic [CFG_W-1:0] refill_threshold;
    logic [CFG_W-1:0] presence_threshold;
    logic [CFG_W-1:0] settle_band;
  } cfg_t;

  // Results of one sample handed to the output queue
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

@@ src/bwed_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bwed_cfg_regs: configuration register file
// Four 16-bit threshold registers written through a plain write port.
// ----------------------------------------------------------------------------
module bwed_cfg_regs import bwed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drink_threshold    <= DRINK_RESET;
      cfg.refill_threshold   <= REFILL_RESET;
      cfg.presence_threshold <= PRESENCE_RESET;
      cfg.settle_band        <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRINK:    cfg.drink_threshold    <= cfg_data;
        CFG_REFILL:   cfg.refill_threshold   <= cfg_data;
        CFG_PRESENCE: cfg.presence_threshold <= cfg_data;
        CFG_SETTLE:   cfg.settle_band        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/bwed_core.sv @@
// ----------------------------------------------------------------------------
// bwed_core: input register and event state machine
// Hold one sample, evaluate it against the bowl state in a single pass and
// push up to two result words into the output queue.
// ----------------------------------------------------------------------------
module bwed_core import bwed_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     queue_room,
  output push_t    push
);

  typedef enum logic [3:0] {
    PH_EMPTY  = 4'b0001,
    PH_PLACED = 4'b0010,
    PH_NORMAL = 4'b0100,
    PH_LOCKED = 4'b1000
  } phase_t;

  logic                       s1_valid;
  logic signed [WEIGHT_W-1:0] s1_weight;
  phase_t                     phase;
  phase_t                     phase_next;
  logic signed [WEIGHT_W-1:0] last_weight;
  logic signed [WEIGHT_W-1:0] last_weight_next;

  logic                     advance;
  logic                     accept;
  logic signed [CALC_W-1:0] w_ext;
  logic signed [CALC_W-1:0] diff;
  logic signed [CALC_W-1:0] neg_diff;
  logic signed [CALC_W-1:0] abs_diff;
  logic signed [CALC_W-1:0] drink_ext;
  logic signed [CALC_W-1:0] refill_ext;
  logic signed [CALC_W-1:0] pres_ext;
  logic signed [CALC_W-1:0] settle_ext;
  logic                     is_drink;
  logic                     is_refill;
  logic                     is_above;
  logic                     is_below;
  logic                     is_settled;
  logic [AMOUNT_W-1:0]      base_amount;

  assign advance  = s1_valid && queue_room;
  assign in_stall = s1_valid && !queue_room;
  assign accept   = in_valid && !in_stall;

  // Drop samples that are not stable at the door: they change nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= in_data.is_stable;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_weight <= in_data.weight;
    end
  end

  assign w_ext      = CALC_W'(s1_weight);
  assign diff       = w_ext - CALC_W'(last_weight);
  assign neg_diff   = CALC_W'(last_weight) - w_ext;
  assign abs_diff   = diff[CALC_W-1] ? neg_diff : diff;
  assign drink_ext  = CALC_W'({1'b0, cfg.drink_threshold});
  assign refill_ext = CALC_W'({1'b0, cfg.refill_threshold});
  assign pres_ext   = CALC_W'({1'b0, cfg.presence_threshold});
  assign settle_ext = CALC_W'({1'b0, cfg.settle_band});

  assign is_drink    = neg_diff >= drink_ext;
  assign is_refill   = diff >= refill_ext;
  assign is_above    = w_ext > pres_ext;
  assign is_below    = w_ext < pres_ext;
  assign is_settled  = abs_diff < settle_ext;
  assign base_amount = s1_weight[WEIGHT_W-1] ? '0 : AMOUNT_W'(s1_weight);

  always_comb begin
    phase_next       = phase;
    last_weight_next = last_weight;
    push             = '0;
    case (phase)
      PH_EMPTY: begin
        if (is_above) begin
          push.count = 2'd1;
          push.first = '{event_code: EV_PLACED, amount: '0, is_last: 1'b1};
          phase_next = PH_PLACED;
        end
      end
      PH_PLACED: begin
        push.count       = 2'd1;
        push.first       = '{event_code: EV_BASELINE, amount: base_amount, is_last: 1'b1};
        last_weight_next = s1_weight;
        phase_next       = PH_NORMAL;
      end
      PH_NORMAL: begin
        if (is_drink || is_refill) begin
          push.count       = 2'd1;
          push.first.event_code = is_drink ? EV_DRINK : EV_REFILL;
          push.first.amount     = is_drink ? AMOUNT_W'(neg_diff) : AMOUNT_W'(diff);
          push.first.is_last    = !is_below;
          last_weight_next = s1_weight;
          phase_next       = PH_LOCKED;
        end
        if (is_below) begin
          if (is_drink || is_refill) begin
            push.count  = 2'd2;
            push.second = '{event_code: EV_REMOVED, amount: '0, is_last: 1'b1};
          end else begin
            push.count = 2'd1;
            push.first = '{event_code: EV_REMOVED, amount: '0, is_last: 1'b1};
          end
          phase_next = PH_EMPTY;
        end
      end
      PH_LOCKED: begin
        if (is_settled) begin
          phase_next = PH_NORMAL;
        end
      end
      default: begin
        phase_next = PH_EMPTY;
      end
    endcase
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_EMPTY;
      last_weight <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      last_weight <= last_weight_next;
    end
  end

endmodule

@@ src/bwed_out_queue.sv @@
// ----------------------------------------------------------------------------
// bwed_out_queue: result word queue
// Four-entry queue taking up to two words a cycle and giving one.
// ----------------------------------------------------------------------------
module bwed_out_queue import bwed_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      queue_room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  out_word_t              mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   pop;

  assign out_valid  = count != '0;
  assign out_data   = mem[rd_ptr];
  assign pop        = out_valid && !out_stall;
  // Room for a two-word sample, judged on the registered fill level
  assign queue_room = count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QUEUE_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      count <= count + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end
  end

endmodule

@@ src/bowl_weight_event_detector_top.sv @@
// ----------------------------------------------------------------------------
// bowl_weight_event_detector_top: bowl weight event detector
// Turns stable load-cell samples into placed, baseline, drink, refill and
// removed events.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while in_stall is low. Each accepted
// word is held in an input register until the queue has room, evaluated in a
// single pass against the bowl state (empty, placed, normal, locked) and its
// results, none, one or two, are written into a four-word output queue; the
// first result thus passes the input register and the queue before it is
// offered on the output. A sample that raises both a drink or refill and a
// removal gives two output words, in that order, the second carrying is_last;
// such a sample fills two output slots, so the sustained rate is one word per
// cycle while each sample gives at most one result and the output does not
// stall. The input stalls when the input register holds a sample and the
// output queue holds more than two words.
// Samples without is_stable are swallowed and give nothing. Weights and
// thresholds are in 1/16 g; amounts saturate at zero for a negative
// baseline. Write the thresholds only while no sample is in flight.
module bowl_weight_event_detector_top import bwed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Sample input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  // Event output
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t  cfg;
  push_t push;
  logic  queue_room;

  // Threshold registers
  bwed_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and state machine: advance only when the queue can take
  // both words of a worst-case sample
  bwed_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_room (queue_room),
    .push       (push)
  );

  // Result queue: parts the output handshake from the evaluation
  bwed_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_room (queue_room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
